/* hw/rtl/rtpj_pkg.sv */
// RTP jitter estimator package: item types, register indexes and constants.
// Has no dependencies. Used by rtp_jitter_estimator and rtpj_checker.
`timescale 1ns / 1ps

package rtpj_pkg;

	localparam int unsigned ADAPT_PERIOD = 50;
	localparam int unsigned PHASE_W      = $clog2(ADAPT_PERIOD + 1);

	// beta = BETA_Q / 2^16, and the product (2^16 - BETA_Q) * BETA_Q for the gap term
	localparam int unsigned BETA_Q       = 655;
	localparam int unsigned ONE_Q        = 65536;
	localparam int unsigned GAP_BETA_Q   = (ONE_Q - BETA_Q) * BETA_Q;

	localparam int unsigned STAMP_W      = 32;
	localparam int unsigned NOMINAL_W    = 24;

	typedef enum logic [0:0] {
		CFG_ADAPTIVE_ENABLE = 1'b0,
		CFG_NOMINAL_TARGET  = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [STAMP_W-1:0] packet_stamp;
		logic [STAMP_W-1:0] local_stamp;
	} in_t;

	typedef struct packed {
		logic signed [32:0] clock_offset;
		logic [48:0]        late_jitter_q16;
		logic [47:0]        arrival_jitter_q16;
		logic [33:0]        target_size;
	} out_t;

endpackage

/* hw/rtl/rtp_jitter_estimator.sv */
// RTP interarrival jitter estimator: offset slide, late-packet jitter and
// interarrival jitter averages, adaptive target size. Depends on rtpj_pkg.
// Items pass the input stage, then the result register; one item per cycle
// while the result is not stalled, the rate set by the state update between
// the two. Asynchronous active-low reset clears config, estimator state and
// both valid flags; nominal_target write restarts the estimation state.
`timescale 1ns / 1ps

module rtp_jitter_estimator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rtpj_pkg::in_t       in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rtpj_pkg::out_t      out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  rtpj_pkg::cfg_index_t cfg_index,
	input  logic [rtpj_pkg::NOMINAL_W-1:0] cfg_data
);

	// config
	logic                            adaptive_q;
	logic [rtpj_pkg::NOMINAL_W-1:0]  nominal_q;

	// estimator state
	logic                            first_seen_q;
	logic [rtpj_pkg::PHASE_W-1:0]    phase_q;
	logic signed [33:0]              offset_q;
	logic [31:0]                     prev_diff_q;
	logic [49:0]                     late_q;
	logic [47:0]                     arrival_q;
	logic [34:0]                     target_q;

	// pipeline
	logic                            vld_s1;
	rtpj_pkg::in_t                   item_s1;
	logic                            out_valid_q;
	rtpj_pkg::out_t                  out_q;
	logic                            adv;

	// datapath
	logic signed [32:0]              diff;
	logic signed [33:0]              off_cur;
	logic [31:0]                     prev_cur;
	logic [49:0]                     late_cur;
	logic signed [34:0]              dlt;
	logic [34:0]                     dmag;
	logic signed [50:0]              slide;
	logic signed [50:0]              slide_rnd;
	logic signed [34:0]              off_trunc;
	logic signed [33:0]              off_new;
	logic [67:0]                     gap_term;
	logic [67:0]                     lsum;
	logic [49:0]                     late_new;
	logic [31:0]                     u_dlt;
	logic [31:0]                     ad;
	logic [52:0]                     asum;
	logic [47:0]                     arrival_new;
	logic [34:0]                     twice;
	logic [34:0]                     nom_ext;
	logic [34:0]                     target_new;
	logic [rtpj_pkg::PHASE_W-1:0]    phase_new;

	assign adv       = vld_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !vld_s1 || adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		diff     = $signed({1'b0, item_s1.packet_stamp} - {1'b0, item_s1.local_stamp});
		off_cur  = first_seen_q ? offset_q : 34'(diff);
		prev_cur = first_seen_q ? prev_diff_q : diff[31:0];
		late_cur = first_seen_q ? late_q : '0;

		dlt  = 35'(diff) - 35'(off_cur);
		dmag = 35'(-dlt);

		// slide, signed with 16 fraction bits (Q34.16): offset + (diff - offset) * beta
		slide     = (51'(off_cur) <<< 16) + 51'(dlt) * signed'(51'(rtpj_pkg::BETA_Q));
		slide_rnd = slide + (slide[50] ? 51'sd65535 : 51'sd0);
		off_trunc = 35'(slide_rnd >>> 16);
		off_new   = off_trunc[33:0];

		// late jitter: floor((late * (1 - beta) + gap * beta) / 2^16)
		gap_term = dlt[34] ? 68'(dmag) * 68'(rtpj_pkg::GAP_BETA_Q) : '0;
		lsum     = (68'(late_cur) << 16) - 68'(late_cur) * 68'(rtpj_pkg::BETA_Q) + gap_term;
		late_new = lsum[65:16];

		// interarrival jitter, delta wrapped to 32 bits
		u_dlt       = diff[31:0] - prev_cur;
		ad          = u_dlt[31] ? (32'd0 - u_dlt) : u_dlt;
		asum        = (53'(arrival_q) << 4) - 53'(arrival_q) + (53'(ad) << 16);
		arrival_new = asum[51:4];

		twice      = late_new[49:15];
		nom_ext    = 35'(nominal_q);
		target_new = (twice > nom_ext) ? twice : nom_ext;

		phase_new = (phase_q == rtpj_pkg::PHASE_W'(rtpj_pkg::ADAPT_PERIOD - 1)) ?
			'0 : phase_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adaptive_q   <= 1'b0;
			nominal_q    <= '0;
			first_seen_q <= 1'b0;
			phase_q      <= '0;
			offset_q     <= '0;
			prev_diff_q  <= '0;
			late_q       <= '0;
			arrival_q    <= '0;
			target_q     <= '0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				unique case (cfg_index)
					rtpj_pkg::CFG_ADAPTIVE_ENABLE: begin
						adaptive_q <= cfg_data[0];
					end
					rtpj_pkg::CFG_NOMINAL_TARGET: begin
						nominal_q    <= cfg_data;
						first_seen_q <= 1'b0;
						phase_q      <= '0;
						offset_q     <= '0;
						prev_diff_q  <= '0;
						late_q       <= '0;
						arrival_q    <= '0;
						target_q     <= 35'(cfg_data);
					end
					default: begin
					end
				endcase
			end else if (adv) begin
				first_seen_q <= 1'b1;
				phase_q      <= phase_new;
				prev_diff_q  <= diff[31:0];
				late_q       <= late_new;
				arrival_q    <= arrival_new;
				if (adaptive_q) begin
					offset_q <= off_new;
					if (phase_q == '0) begin
						target_q <= target_new;
					end
				end else begin
					offset_q <= off_cur;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (adv) begin
			out_q.clock_offset       <= adaptive_q ? off_new[32:0] : off_cur[32:0];
			out_q.late_jitter_q16    <= late_new[48:0];
			out_q.arrival_jitter_q16 <= arrival_new;
			out_q.target_size        <= (adaptive_q && phase_q == '0) ?
				target_new[33:0] : target_q[33:0];
		end
	end

endmodule

/* hw/rtl/rtpj_checker.sv */
// Port-level checks for rtp_jitter_estimator, attached by bind.
// Depends on rtpj_pkg.
`timescale 1ns / 1ps

module rtpj_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  rtpj_pkg::out_t       out_data
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result item without an accepted input item");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items in flight");

	a_arrival_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.arrival_jitter_q16 <= 48'h8000_0000_0000)
		else $error("interarrival jitter above its bound");

endmodule

bind rtp_jitter_estimator rtpj_checker u_rtpj_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for rtp_jitter_estimator: a queued item driver, a result
// monitor and an item-level predictor of the jitter estimator.
// Depends on rtpj_pkg and the rtp_jitter_estimator RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE = 8;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 156;
	localparam longint BETA = rtpj_pkg::BETA_Q;
	localparam longint ONE = rtpj_pkg::ONE_Q;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rtpj_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rtpj_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	rtpj_pkg::cfg_index_t cfg_index = rtpj_pkg::CFG_ADAPTIVE_ENABLE;
	logic [rtpj_pkg::NOMINAL_W-1:0] cfg_data = '0;

	rtpj_pkg::in_t pending_packets[$];
	rtpj_pkg::out_t expected_estimates[$];
	int unsigned queued_total = 0;
	int unsigned accepted_total = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned stall_requests = 0;
	int unsigned stall_served = 0;
	int unsigned stall_left = 0;

	// predictor state
	bit adapt_en = 1'b0;
	logic [rtpj_pkg::NOMINAL_W-1:0] nominal = '0;
	bit first_seen;
	int unsigned phase_count;
	logic signed [33:0] offset_est;
	logic signed [33:0] prev_diff;
	logic [49:0] late_avg;
	logic [47:0] arrival_avg;
	logic [34:0] target_reg;

	rtp_jitter_estimator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic void restart_estimation();
		first_seen = 1'b0;
		phase_count = 0;
		offset_est = '0;
		prev_diff = '0;
		late_avg = '0;
		arrival_avg = '0;
		target_reg = 35'(nominal);
	endfunction

	function automatic void apply_register(rtpj_pkg::cfg_index_t idx,
		logic [rtpj_pkg::NOMINAL_W-1:0] val);
		case (idx)
			rtpj_pkg::CFG_ADAPTIVE_ENABLE: adapt_en = val[0];
			rtpj_pkg::CFG_NOMINAL_TARGET: begin
				nominal = val;
				restart_estimation();
			end
			default: ;
		endcase
	endfunction

	function automatic rtpj_pkg::out_t estimate_jitter(rtpj_pkg::in_t pkt);
		longint d, slide_q, g;
		logic [63:0] gap_q, mag, twice;
		logic [79:0] late_acc;
		logic [31:0] delta;
		rtpj_pkg::out_t r;
		d = longint'({32'h0, pkt.packet_stamp}) - longint'({32'h0, pkt.local_stamp});
		if (!first_seen) begin
			offset_est = d[33:0];
			prev_diff = d[33:0];
			late_avg = '0;
			slide_q = d * ONE;
			first_seen = 1'b1;
		end else begin
			slide_q = longint'(offset_est) * (ONE - BETA) + d * BETA;
		end
		g = d * ONE - slide_q;
		gap_q = (g < 0) ? 64'(-g) : 64'h0;
		late_acc = 80'(late_avg) * 80'(ONE - BETA) + 80'(gap_q) * 80'(BETA);
		late_avg = 50'(late_acc >> 16);
		// interarrival delta wraps like RTP timestamp arithmetic
		delta = 32'(d - longint'(prev_diff));
		mag = delta[31] ? {32'h0, 32'h0 - delta} : {32'h0, delta};
		arrival_avg = 48'((64'(arrival_avg) * 64'd15 + (mag << 16)) >> 4);
		prev_diff = d[33:0];
		if (adapt_en) begin
			if (phase_count == 0) begin
				twice = 64'(late_avg) >> 15;
				target_reg = (twice > 64'(nominal)) ? 35'(twice) : 35'(nominal);
			end
			offset_est = 34'(slide_q / ONE);
		end
		phase_count = (phase_count + 1 >= rtpj_pkg::ADAPT_PERIOD) ? 0 : phase_count + 1;
		r.clock_offset = offset_est[32:0];
		r.late_jitter_q16 = late_avg[48:0];
		r.arrival_jitter_q16 = arrival_avg;
		r.target_size = target_reg[33:0];
		return r;
	endfunction

	always @(posedge clk) begin : drive_packets
		if (in_valid && in_ready) begin
			expected_estimates.push_back(estimate_jitter(in_data));
			accepted_total++;
		end
		if (!in_valid || in_ready) begin
			if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_packets.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : drive_ready
		if (stall_requests != stall_served) begin
			stall_served++;
			stall_left = 400;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %h, got %h", what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		rtpj_pkg::out_t want;
		if (out_valid && out_ready) begin
			if (expected_estimates.size() == 0) begin
				note_mismatch("result with no item pending", '0, 64'(out_data));
			end else begin
				want = expected_estimates.pop_front();
				if (out_data.clock_offset !== want.clock_offset)
					note_mismatch("clock_offset", 64'(want.clock_offset),
						64'(out_data.clock_offset));
				if (out_data.late_jitter_q16 !== want.late_jitter_q16)
					note_mismatch("late_jitter_q16", 64'(want.late_jitter_q16),
						64'(out_data.late_jitter_q16));
				if (out_data.arrival_jitter_q16 !== want.arrival_jitter_q16)
					note_mismatch("arrival_jitter_q16", 64'(want.arrival_jitter_q16),
						64'(out_data.arrival_jitter_q16));
				if (out_data.target_size !== want.target_size)
					note_mismatch("target_size", 64'(want.target_size),
						64'(out_data.target_size));
			end
		end
	end

	task automatic write_register(rtpj_pkg::cfg_index_t idx,
		logic [rtpj_pkg::NOMINAL_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_register(idx, val);
	endtask

	task automatic queue_packet(logic [31:0] pkt, logic [31:0] loc);
		rtpj_pkg::in_t item;
		item.packet_stamp = pkt;
		item.local_stamp = loc;
		pending_packets.push_back(item);
		queued_total++;
	endtask

	task automatic wait_idle();
		while (accepted_total != queued_total || expected_estimates.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// steady stream: local clock advancing, packet stamps at a fixed offset plus jitter
	task automatic queue_stream(int unsigned n);
		int unsigned loc, offs, amp, step_max;
		loc = $urandom;
		offs = $urandom;
		step_max = $urandom_range(1, 4000);
		case ($urandom_range(3))
			0: amp = 0;
			1: amp = $urandom_range(1, 64);
			2: amp = $urandom_range(100, 20000);
			default: amp = $urandom_range(1 << 20, 1 << 28);
		endcase
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(99) < 3)
				loc += $urandom;
			else
				loc += $urandom_range(1, step_max);
			queue_packet(loc + offs + $urandom_range(0, amp), loc);
		end
	endtask

	initial begin : sequencer
		int unsigned goal;
		int unsigned burst;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_register(rtpj_pkg::CFG_ADAPTIVE_ENABLE, 24'h1);
		write_register(rtpj_pkg::CFG_NOMINAL_TARGET, 24'hFFFFFF);
		queue_packet(32'h0, 32'h0);
		queue_packet(32'hFFFFFFFF, 32'h0);
		queue_packet(32'h0, 32'hFFFFFFFF);
		queue_packet(32'h80000000, 32'h0);
		queue_packet(32'h0, 32'h0);
		queue_packet(32'h7FFFFFFF, 32'h0);
		queue_packet(32'h0, 32'h80000000);
		for (int unsigned i = 1; i <= 6; i++)
			queue_packet(i * 1000 + 500, i * 1000);
		for (int unsigned i = 7; i <= 10; i++)
			queue_packet(i * 1000 + 100, i * 1000);
		queue_packet(11000 + 5000, 11000);
		queue_packet(32'hFFFFFFFF, 32'hFFFFFFFF);
		queue_packet(32'hAAAAAAAA, 32'h55555555);
		queue_packet(32'h55555555, 32'hAAAAAAAA);
		wait_idle();

		// adaptation off keeps the running state
		write_register(rtpj_pkg::CFG_ADAPTIVE_ENABLE,
			{23'($urandom_range(0, (1 << 23) - 1)), 1'b0});
		queue_packet(32'h12345678, 32'h12340000);
		queue_packet(32'h12345000, 32'h12341000);
		queue_packet(32'hFFFF0000, 32'h00010000);
		wait_idle();

		write_register(rtpj_pkg::CFG_NOMINAL_TARGET, 24'h0);
		queue_packet(32'h00000100, 32'hFFFFFF00);
		queue_packet(32'h00000300, 32'h00000000);
		queue_packet(32'h00000200, 32'h00000100);
		wait_idle();

		for (int unsigned p = 0; p < PHASES; p++) begin
			write_register(rtpj_pkg::CFG_ADAPTIVE_ENABLE,
				{23'($urandom_range(0, (1 << 23) - 1)), 1'(p % 3 != 1)});
			if (p != 3 && p != 6) begin
				case (p % 4)
					0: write_register(rtpj_pkg::CFG_NOMINAL_TARGET, 24'hFFFFFF);
					1: write_register(rtpj_pkg::CFG_NOMINAL_TARGET, 24'h0);
					2: write_register(rtpj_pkg::CFG_NOMINAL_TARGET, 24'($urandom));
					default: write_register(rtpj_pkg::CFG_NOMINAL_TARGET,
						24'($urandom_range(0, 5000)));
				endcase
			end
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			if (p == 4)
				stall_requests++;
			goal = queued_total + PHASE_ITEMS;
			while (queued_total < goal) begin
				if ($urandom_range(99) < 85) begin
					burst = $urandom_range(10, 80);
					if (burst > goal - queued_total)
						burst = goal - queued_total;
					queue_stream(burst);
				end else begin
					repeat ($urandom_range(1, 3))
						queue_packet($urandom, $urandom);
				end
			end
			wait_idle();
		end

		if (errors == 0 && expected_estimates.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/rtpj_pkg.sv
hw/rtl/rtp_jitter_estimator.sv
hw/rtl/rtpj_checker.sv
sim/testbench.sv
